FILE: rtl/intel_hex_record_parser_assert.svh
// assertion macros used by the parser rtl
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define IHEX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ihex assertion failed");

// next-cycle implication, disabled while reset is low
`define IHEX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ihex assertion failed");

`endif

FILE: rtl/ihex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_pkg
// shared types and constants of the intel hex record parser
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam int          POS_W       = 10;
    localparam logic [9:0]  POS_MAX     = 10'd1023;
    localparam logic [9:0]  MIN_LINE    = 10'd11;
    localparam logic [7:0]  MAX_LEN_RST = 8'hFF;
    localparam int          QUEUE_DEPTH = 2;
    localparam int          TDATA_W     = 64;

    // record status codes
    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_TERM     = 3'd1;
    localparam logic [2:0] ST_SKIP     = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;
    localparam logic [2:0] ST_CSUM     = 3'd5;
    localparam logic [2:0] ST_BAD_HEX  = 3'd6;

    // error flag bits
    localparam int ERR_LEN  = 0;
    localparam int ERR_ADDR = 1;
    localparam int ERR_TYPE = 2;
    localparam int ERR_DATA = 3;

    // classified character
    typedef struct packed {
        logic       is_cr;
        logic       is_lf;
        logic       is_colon;
        logic       hex_ok;
        logic [3:0] nibble;
    } item_t;

    typedef struct packed {
        logic        is_status;
        logic [15:0] line_number;
        logic [2:0]  record_status;
        logic [7:0]  record_length;
        logic [15:0] record_address;
        logic [7:0]  byte_index;
        logic [7:0]  data_byte;
    } result_t;

endpackage

FILE: rtl/ihex_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_front
// accepts text characters and classifies them into line control and hex digits
// ----------------------------------------------------------------------------
module ihex_front import ihex_pkg::*; (
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       q_full,
    output logic       q_push,
    output item_t      q_item
);

    logic [7:0] c;

    assign c        = s_tdata;
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item          = '0;
        q_item.is_cr    = (c == CHAR_CR);
        q_item.is_lf    = (c == CHAR_LF);
        q_item.is_colon = (c == CHAR_COLON);
        if (c inside {[8'h30:8'h39]}) begin
            q_item.hex_ok = 1'b1;
            q_item.nibble = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            q_item.hex_ok = 1'b1;
            q_item.nibble = c[3:0] + 4'd9;
        end
    end

endmodule

FILE: rtl/ihex_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_queue
// short register queue between the classifier and the record parser
// ----------------------------------------------------------------------------
module ihex_queue import ihex_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head_item,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/ihex_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_back
// record parser: line state, checksum, data byte and status results
// ----------------------------------------------------------------------------
module ihex_back import ihex_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        q_empty,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             colon_reg, colon_next;
    logic [3:0]       hold_reg, hold_next;
    logic [7:0]       len_reg, len_next;
    logic [15:0]      addr_reg, addr_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       csum_reg, csum_next;
    logic [3:0]       err_reg, err_next;
    logic [15:0]      line_reg, line_next;
    logic [7:0]       max_len_reg;
    logic             valid_reg, valid_next;
    result_t          res_reg, res_next;

    logic [POS_W-1:0] pm1;
    logic [8:0]       k;
    logic [8:0]       end_k;
    logic [3:0]       v;
    logic [3:0]       flag;
    logic [7:0]       b;
    logic [2:0]       line_code;
    logic [9:0]       need_pos;
    logic             type_ok;
    logic             emit;

    assign q_pop     = !q_empty && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res       = res_reg;

    assign pm1      = pos_reg - 1'b1;
    assign k        = pm1[POS_W-1:1];
    assign end_k    = 9'd4 + {1'b0, len_reg};
    assign need_pos = MIN_LINE + {1'b0, len_reg, 1'b0};
    assign type_ok  = (type_reg == 8'd0) || (type_reg == 8'd1);
    assign v        = q_item.hex_ok ? q_item.nibble : 4'd0;
    assign b        = {hold_reg, v};

    always_comb begin
        if (k == 9'd0) begin
            flag = 4'b0001;
        end else if (k <= 9'd2) begin
            flag = 4'b0010;
        end else if (k == 9'd3) begin
            flag = 4'b0100;
        end else begin
            flag = 4'b1000;
        end
    end

    // end-of-line status in priority order
    always_comb begin
        if (!colon_reg) begin
            line_code = ST_SKIP;
        end else if (pos_reg < MIN_LINE) begin
            line_code = ST_SHORT;
        end else if (err_reg[ERR_LEN]) begin
            line_code = ST_BAD_HEX;
        end else if (len_reg > max_len_reg) begin
            line_code = ST_TOO_LONG;
        end else if (pos_reg < need_pos) begin
            line_code = ST_SHORT;
        end else if (err_reg[ERR_ADDR]) begin
            line_code = ST_BAD_HEX;
        end else if (err_reg[ERR_TYPE] || !type_ok) begin
            line_code = ST_SKIP;
        end else if (err_reg[ERR_DATA]) begin
            line_code = ST_BAD_HEX;
        end else if (sum_reg + csum_reg != 8'd0) begin
            line_code = ST_CSUM;
        end else begin
            line_code = type_reg[0] ? ST_TERM : ST_DATA;
        end
    end

    always_comb begin
        pos_next   = pos_reg;
        colon_next = colon_reg;
        hold_next  = hold_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        type_next  = type_reg;
        sum_next   = sum_reg;
        csum_next  = csum_reg;
        err_next   = err_reg;
        line_next  = line_reg;
        emit       = 1'b0;
        res_next   = '0;
        res_next.record_address = addr_reg;
        res_next.record_length  = len_reg;
        res_next.line_number    = line_reg;

        if (q_pop && !q_item.is_cr) begin
            if (q_item.is_lf) begin
                emit                   = 1'b1;
                res_next.is_status     = 1'b1;
                res_next.record_status = line_code;
                if (line_reg != 16'hFFFF) begin
                    line_next = line_reg + 1'b1;
                end
                pos_next   = '0;
                colon_next = 1'b0;
                hold_next  = '0;
                len_next   = '0;
                addr_next  = '0;
                type_next  = '0;
                sum_next   = '0;
                csum_next  = '0;
                err_next   = '0;
            end else begin
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + 1'b1;
                end
                if (pos_reg == '0) begin
                    colon_next = q_item.is_colon;
                end else if (colon_reg && k <= end_k) begin
                    if (!q_item.hex_ok) begin
                        err_next = err_reg | flag;
                    end
                    if (!pm1[0]) begin
                        hold_next = v;
                    end else if (k == end_k) begin
                        csum_next = b;
                    end else begin
                        case (k)
                            9'd0:    len_next  = b;
                            9'd1:    addr_next = {b, addr_reg[7:0]};
                            9'd2:    addr_next = {addr_reg[15:8], b};
                            9'd3:    type_next = b;
                            default: ;
                        endcase
                        sum_next = sum_reg + b;
                        if (k >= 9'd4 && !err_reg[ERR_TYPE] && type_ok &&
                            len_reg <= max_len_reg) begin
                            emit                = 1'b1;
                            res_next.data_byte  = b;
                            res_next.byte_index = 8'(k - 9'd4);
                        end
                    end
                end
            end
        end

        if (emit) begin
            valid_next = 1'b1;
        end else if (res_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            colon_reg   <= 1'b0;
            hold_reg    <= '0;
            len_reg     <= '0;
            addr_reg    <= '0;
            type_reg    <= '0;
            sum_reg     <= '0;
            csum_reg    <= '0;
            err_reg     <= '0;
            line_reg    <= 16'd1;
            max_len_reg <= MAX_LEN_RST;
            valid_reg   <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            colon_reg <= colon_next;
            hold_reg  <= hold_next;
            len_reg   <= len_next;
            addr_reg  <= addr_next;
            type_reg  <= type_next;
            sum_reg   <= sum_next;
            csum_reg  <= csum_next;
            err_reg   <= err_next;
            line_reg  <= line_next;
            valid_reg <= valid_next;
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: rtl/intel_hex_record_parser.sv
`timescale 1ns / 1ps
// path: an accepted character is stored in the queue, and the record parser then registers any result from it
// throughput: one character per cycle while the queue is not full; the record parser takes one queued item per cycle
// and stalls only while its output register holds a result that is not yet taken
// reset: synchronous, active low; clears line state and queue, line count to one,
// max_record_len to 255
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// intel hex text parser emitting data bytes and per-line record status
// ----------------------------------------------------------------------------
`include "intel_hex_record_parser_assert.svh"

module intel_hex_record_parser import ihex_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,  // [7:0] max_record_len
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] char_in
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] data_byte, [15:8] byte_index, [31:16] record_address,
    // [39:32] record_length, [42:40] record_status, [58:43] line_number, rest zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser     // [0] is_status
);

    item_t   push_item;
    item_t   head_item;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    result_t res;

    ihex_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    ihex_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    ihex_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_empty   (q_empty),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tuser = res.is_status;
    assign m_tdata = {5'd0, res.line_number, res.record_status, res.record_length,
                      res.record_address, res.byte_index, res.data_byte};

    `IHEX_ASSERT_IMP(a_status_no_data, aclk, aresetn, m_tvalid && m_tuser, m_tdata[15:0] == 16'd0)
    `IHEX_ASSERT_IMP(a_data_code_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[42:40] == ST_DATA)
    `IHEX_ASSERT_IMP(a_index_in_len, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[15:8] < m_tdata[39:32])
    `IHEX_ASSERT_NXT(a_pop_needs_item, aclk, aresetn, q_empty && !q_push, !q_pop)

endmodule

FILE: sim/tb_intel_hex_record_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_intel_hex_record_parser
// feeds hex text one character per item: a few hand-written lines, then
// random records (mostly well formed, some broken) and noise under several
// length limits, the last part without idling; a built-in line parser
// predicts every data byte and line status and the monitor checks each
// output item field by field
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser;
    import ihex_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PAUSE_MARK  = -1;
    localparam int REPORT_MAX  = 40;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_UP_A = 8'h41;
    localparam logic [7:0] ASCII_UP_F = 8'h46;
    localparam logic [7:0] ASCII_LO_A = 8'h61;
    localparam logic [7:0] ASCII_LO_F = 8'h66;

    typedef enum int {
        FLAW_NONE,
        FLAW_CSUM,
        FLAW_HEX,
        FLAW_TRUNC,
        FLAW_TAIL,
        FLAW_NOCOLON
    } flaw_e;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [7:0]          cfg_wdata = 8'd0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = 8'd0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;

    // text waiting to be sent, with pause marks, and results still awaited
    int          text_q[$];
    result_t     parsed_q[$];
    logic [7:0]  line_buf[$];

    int fail_count   = 0;
    int pushed_count = 0;
    int cycle_count  = 0;
    bit no_idle      = 1'b0;

    int tx_gap_left = 0, tx_mode_left = 0;
    int rx_stall_left = 0, rx_mode_left = 0;
    bit tx_bursty = 1'b0, rx_bursty = 1'b0;

    // line parser state
    logic [9:0]  ln_pos;
    logic        ln_colon;
    logic [3:0]  ln_nibble;
    logic [7:0]  ln_len;
    logic [15:0] ln_addr;
    logic [7:0]  ln_type;
    logic [7:0]  ln_sum;
    logic [7:0]  ln_csum;
    logic [3:0]  ln_err;
    logic [15:0] line_no;
    logic [7:0]  max_len_cfg;

    intel_hex_record_parser i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // {ok, value}; value is zero when the character is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= ASCII_ZERO && c <= ASCII_NINE) return {1'b1, 4'(c - ASCII_ZERO)};
        if (c >= ASCII_UP_A && c <= ASCII_UP_F) return {1'b1, 4'(c - ASCII_UP_A + 8'd10)};
        if (c >= ASCII_LO_A && c <= ASCII_LO_F) return {1'b1, 4'(c - ASCII_LO_A + 8'd10)};
        return 5'd0;
    endfunction

    task automatic clear_line_state();
        ln_pos    = '0;
        ln_colon  = 1'b0;
        ln_nibble = '0;
        ln_len    = '0;
        ln_addr   = '0;
        ln_type   = '0;
        ln_sum    = '0;
        ln_csum   = '0;
        ln_err    = '0;
    endtask

    function automatic logic [2:0] line_verdict();
        if (!ln_colon) return ST_SKIP;
        if (ln_pos < MIN_LINE) return ST_SHORT;
        if (ln_err[ERR_LEN]) return ST_BAD_HEX;
        if (ln_len > max_len_cfg) return ST_TOO_LONG;
        if (int'(ln_pos) < int'(MIN_LINE) + 2 * int'(ln_len)) return ST_SHORT;
        if (ln_err[ERR_ADDR]) return ST_BAD_HEX;
        if (ln_err[ERR_TYPE]) return ST_SKIP;
        if (ln_type > 8'd1) return ST_SKIP;
        if (ln_err[ERR_DATA]) return ST_BAD_HEX;
        if (8'(ln_sum + ln_csum) != 8'd0) return ST_CSUM;
        return (ln_type == 8'd0) ? ST_DATA : ST_TERM;
    endfunction

    task automatic parse_char(input logic [7:0] c);
        logic [9:0] p;
        int         k;
        logic [4:0] hv;
        logic [3:0] flag;
        logic [7:0] b;
        result_t    r;
        r = '0;
        if (c == CHAR_CR) return;
        if (c == CHAR_LF) begin
            r.is_status      = 1'b1;
            r.record_address = ln_addr;
            r.record_length  = ln_len;
            r.record_status  = line_verdict();
            r.line_number    = line_no;
            parsed_q.push_back(r);
            if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
            clear_line_state();
            return;
        end
        p = ln_pos;
        if (ln_pos < POS_MAX) ln_pos = ln_pos + 10'd1;
        if (p == 10'd0) begin
            ln_colon = (c == CHAR_COLON);
            return;
        end
        if (!ln_colon) return;
        k = (int'(p) - 1) >>> 1;
        // past the checksum: counted only
        if (k > 4 + int'(ln_len)) return;
        if (k == 0) flag = 4'(1 << ERR_LEN);
        else if (k <= 2) flag = 4'(1 << ERR_ADDR);
        else if (k == 3) flag = 4'(1 << ERR_TYPE);
        else flag = 4'(1 << ERR_DATA);
        hv = hex_nibble(c);
        if (!hv[4]) ln_err = ln_err | flag;
        if (p[0]) begin
            ln_nibble = hv[3:0];
            return;
        end
        b = {ln_nibble, hv[3:0]};
        if (k == 0) begin
            ln_len = b;
        end else if (k == 1) begin
            ln_addr[15:8] = b;
        end else if (k == 2) begin
            ln_addr[7:0] = b;
        end else if (k == 3) begin
            ln_type = b;
        end else if (k == 4 + int'(ln_len)) begin
            ln_csum = b;
            return;
        end
        ln_sum = ln_sum + b;
        if (k >= 4 && !ln_err[ERR_TYPE] && ln_type <= 8'd1 && ln_len <= max_len_cfg) begin
            r.data_byte      = b;
            r.byte_index     = 8'(k - 4);
            r.record_address = ln_addr;
            r.record_length  = ln_len;
            r.record_status  = ST_DATA;
            r.line_number    = line_no;
            parsed_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
    endtask

    task automatic check_output();
        result_t want;
        if (parsed_q.size() == 0) begin
            report_mismatch("item with nothing awaited", m_tdata, 64'd0);
            return;
        end
        want = parsed_q.pop_front();
        if (m_tuser !== want.is_status)
            report_mismatch("is_status", 64'(m_tuser), 64'(want.is_status));
        if (m_tdata[7:0] !== want.data_byte)
            report_mismatch("data_byte", 64'(m_tdata[7:0]), 64'(want.data_byte));
        if (m_tdata[15:8] !== want.byte_index)
            report_mismatch("byte_index", 64'(m_tdata[15:8]), 64'(want.byte_index));
        if (m_tdata[31:16] !== want.record_address)
            report_mismatch("record_address", 64'(m_tdata[31:16]), 64'(want.record_address));
        if (m_tdata[39:32] !== want.record_length)
            report_mismatch("record_length", 64'(m_tdata[39:32]), 64'(want.record_length));
        if (m_tdata[42:40] !== want.record_status)
            report_mismatch("record_status", 64'(m_tdata[42:40]), 64'(want.record_status));
        if (m_tdata[58:43] !== want.line_number)
            report_mismatch("line_number", 64'(m_tdata[58:43]), 64'(want.line_number));
        if (m_tdata[63:59] !== 5'd0)
            report_mismatch("tdata padding", 64'(m_tdata[63:59]), 64'd0);
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (tx_mode_left == 0) begin
                tx_mode_left = $urandom_range(50, 300);
                tx_bursty    = ($urandom_range(0, 2) != 0);
            end else begin
                tx_mode_left--;
            end
            if (s_tvalid && s_tready) parse_char(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    s_tvalid <= 1'b0;
                end else if (!no_idle && tx_bursty && $urandom_range(0, 7) == 0) begin
                    tx_gap_left = $urandom_range(1, 19) - 1;
                    s_tvalid <= 1'b0;
                end else if (text_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (text_q[0] == PAUSE_MARK) begin
                    // hold off until everything sent so far has come out
                    if (parsed_q.size() == 0) void'(text_q.pop_front());
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= 8'(text_q.pop_front());
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode_left = $urandom_range(50, 300);
                rx_bursty    = ($urandom_range(0, 2) != 0);
            end else begin
                rx_mode_left--;
            end
            if (m_tvalid && m_tready) check_output();
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                m_tready <= 1'b0;
            end else if (!no_idle && rx_bursty && $urandom_range(0, 7) == 0) begin
                rx_stall_left = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_char(input logic [7:0] c);
        text_q.push_back(int'(c));
        pushed_count++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return ASCII_ZERO + 8'(n);
        return ($urandom_range(0, 1) ? ASCII_UP_A : ASCII_LO_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [4:0] hv;
        do begin
            c  = 8'($urandom_range(0, 255));
            hv = hex_nibble(c);
        end while (hv[4] || c == CHAR_LF || c == CHAR_CR);
        return c;
    endfunction

    function automatic logic [7:0] non_lf_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CHAR_LF);
        return c;
    endfunction

    task automatic buf_byte(input logic [7:0] b);
        line_buf.push_back(hex_char(b[7:4]));
        line_buf.push_back(hex_char(b[3:0]));
    endtask

    task automatic flush_line();
        while (line_buf.size() > 0) push_char(line_buf.pop_front());
        push_char(CHAR_LF);
    endtask

    // one record; forced_tail > 0 gives a clean record followed by that much junk
    task automatic add_record(input int len, input int forced_tail);
        logic [7:0]  rtype, b, sum;
        logic [15:0] addr;
        flaw_e       flaw;
        int          r, n;
        r = $urandom_range(0, 19);
        rtype = (r < 14) ? 8'd0 : (r < 17) ? 8'd1 : 8'($urandom_range(0, 255));
        addr  = 16'($urandom);
        case ($urandom_range(0, 11))
            6:       flaw = FLAW_CSUM;
            7:       flaw = FLAW_HEX;
            8:       flaw = FLAW_TRUNC;
            9:       flaw = FLAW_TAIL;
            10:      flaw = FLAW_NOCOLON;
            default: flaw = FLAW_NONE;
        endcase
        if (forced_tail > 0) flaw = FLAW_NONE;
        sum = 8'(len) + addr[15:8] + addr[7:0] + rtype;
        line_buf.push_back(CHAR_COLON);
        buf_byte(8'(len));
        buf_byte(addr[15:8]);
        buf_byte(addr[7:0]);
        buf_byte(rtype);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            sum = sum + b;
            buf_byte(b);
        end
        if (flaw == FLAW_CSUM) buf_byte(8'(-sum) + 8'($urandom_range(1, 255)));
        else buf_byte(8'(-sum));
        case (flaw)
            FLAW_HEX: line_buf[$urandom_range(1, line_buf.size() - 1)] = non_hex_char();
            FLAW_TRUNC: begin
                n = $urandom_range(1, line_buf.size() - 1);
                while (line_buf.size() > n) void'(line_buf.pop_back());
            end
            FLAW_TAIL: begin
                n = $urandom_range(1, 6);
                repeat (n) line_buf.push_back(non_lf_char());
            end
            FLAW_NOCOLON: begin
                do line_buf[0] = non_lf_char();
                while (line_buf[0] == CHAR_COLON);
            end
            default: ;
        endcase
        repeat (forced_tail) line_buf.push_back(non_lf_char());
        if ($urandom_range(0, 3) == 0)
            line_buf.insert($urandom_range(0, line_buf.size()), CHAR_CR);
        flush_line();
    endtask

    function automatic int pick_len(input int hi);
        if ($urandom_range(0, 3) == 0 || hi < 8) return $urandom_range(0, hi);
        return $urandom_range(0, 8);
    endfunction

    task automatic add_random_line(input int len_hi);
        int r, n;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            // noise, sometimes behind a colon
            if (r == 1) line_buf.push_back(CHAR_COLON);
            n = $urandom_range(0, 14);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            flush_line();
        end else begin
            add_record(pick_len(len_hi), 0);
        end
    endtask

    task automatic random_lines(input int n_items, input int len_hi);
        int start;
        start = pushed_count;
        while (pushed_count - start < n_items) begin
            add_random_line(len_hi);
            if ($urandom_range(0, 24) == 0) text_q.push_back(PAUSE_MARK);
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (text_q.size() != 0 || s_tvalid || parsed_q.size() != 0);
        // items that give no output may still be in the pipe
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_max_len(input logic [7:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        max_len_cfg = v;
    endtask

    initial begin
        clear_line_state();
        line_no     = 16'd1;
        max_len_cfg = MAX_LEN_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // hand-written lines at the reset limit
        push_text(":00000001FF");
        push_char(CHAR_LF);
        push_text(":01001000559A");
        push_char(CHAR_CR);
        push_char(CHAR_LF);
        push_char(CHAR_LF);
        push_text(":0");
        push_char(CHAR_LF);
        push_char(8'h00);
        push_char(8'hFF);
        push_char(CHAR_LF);
        wait_drained();

        set_max_len(8'd0);
        random_lines(200, 3);
        wait_drained();

        set_max_len(8'($urandom_range(2, 12)));
        random_lines(400, int'(max_len_cfg) + 4);
        wait_drained();

        set_max_len(8'hFF);
        random_lines(450, 24);
        wait_drained();

        set_max_len(8'd8);
        no_idle = 1'b1;
        random_lines(250, 12);
        wait_drained();

        if (parsed_q.size() != 0)
            report_mismatch("results never produced", 64'(parsed_q.size()), 64'd0);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ihex_pkg.sv
rtl/ihex_front.sv
rtl/ihex_queue.sv
rtl/ihex_back.sv
rtl/intel_hex_record_parser.sv
sim/tb_intel_hex_record_parser.sv
